FILE: rtl/triangle_max_path_sum_defines.svh
// assertion macros for the triangle max path sum block
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef TRIANGLE_MAX_PATH_SUM_DEFINES_SVH
`define TRIANGLE_MAX_PATH_SUM_DEFINES_SVH

// consequent checked in the same cycle
`define TPMS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define TPMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tpms_pkg.sv
// shared types and constants for the triangle max path sum block
// no dependencies
package tpms_pkg;

    localparam int SUM_BITS        = 23;
    localparam int ROW_COUNT_BITS  = 8;
    localparam int OUT_TDATA_BITS  = ((SUM_BITS + 7) / 8) * 8;
    localparam int DEF_MAX_ROWS    = 128;
    localparam int DEF_VALUE_BITS  = 16;

    localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

    // control from the row walker to the cell chain
    typedef struct packed {
        logic clear;    // drop the buffered row, triangle finished
        logic push;     // store a new sum at the tail
        logic pop;      // head was consumed, shift toward the head
    } t_chain_ctl;

endpackage

FILE: rtl/triangle_max_path_sum.sv
// triangle max path sum, top level: row walker, saturating adder, result register
// depends on tpms_pkg, tpms_chain, tpms_cell and triangle_max_path_sum_defines.svh
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata: value (VALUE_BITS, zero padded)
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: best_sum (23 bits, zero padded)
//  cfg       in   i_cfg_we                       i_cfg_wdata: row_count (8 bits)
//
// one element per cycle while s_axis is not stalled: each element is one add and one
// compare against the head cell of the row buffer chain, which shifts by one once the head is consumed
// a result appears on m_axis the cycle after the last element of the final row
// s_axis stalls only on a triangle's last element while the previous result is unread
// synchronous active-low reset; no clearing pass, the chain holds no valid data after reset
`include "triangle_max_path_sum_defines.svh"

module triangle_max_path_sum #(
    parameter int MAX_ROWS   = tpms_pkg::DEF_MAX_ROWS,
    parameter int VALUE_BITS = tpms_pkg::DEF_VALUE_BITS
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    // configuration
    input  logic                                      i_cfg_we,
    input  logic [tpms_pkg::ROW_COUNT_BITS-1:0]       i_cfg_wdata,   // row_count
    // element stream
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  logic [((VALUE_BITS + 7) / 8) * 8-1:0]     s_axis_tdata,  // value
    // result stream
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    output logic [tpms_pkg::OUT_TDATA_BITS-1:0]       m_axis_tdata   // best_sum
);

    localparam int IDX_W = $clog2(MAX_ROWS);
    localparam int CNT_W = $clog2(MAX_ROWS + 1);
    localparam int CMP_W = (tpms_pkg::ROW_COUNT_BITS > CNT_W) ? tpms_pkg::ROW_COUNT_BITS
                                                               : CNT_W;
    localparam int ADD_W = ((VALUE_BITS > tpms_pkg::SUM_BITS) ? VALUE_BITS
                                                              : tpms_pkg::SUM_BITS) + 1;

    // control state
    logic [IDX_W-1:0]              r_last_idx;   // index of the final row
    logic [IDX_W-1:0]              n_last_idx;
    logic [IDX_W-1:0]              r_row;
    logic [IDX_W-1:0]              n_row;
    logic [IDX_W-1:0]              r_col;
    logic [IDX_W-1:0]              n_col;
    logic [tpms_pkg::SUM_BITS-1:0] r_left;       // previous row sum left of the current column
    logic [tpms_pkg::SUM_BITS-1:0] n_left;
    logic [tpms_pkg::SUM_BITS-1:0] r_max;        // best sum seen in the final row so far
    logic [tpms_pkg::SUM_BITS-1:0] n_max;
    logic                          r_out_valid;
    logic                          n_out_valid;
    logic [tpms_pkg::SUM_BITS-1:0] r_out_sum;
    logic [tpms_pkg::SUM_BITS-1:0] n_out_sum;

    logic                          w_accept;
    logic                          w_row_end;
    logic                          w_last_row;
    logic                          w_done;
    logic                          w_has_above;
    logic [VALUE_BITS-1:0]         w_value;
    logic [tpms_pkg::SUM_BITS-1:0] w_above;
    logic [tpms_pkg::SUM_BITS-1:0] w_parent;
    logic [ADD_W-1:0]              w_wide;
    logic [tpms_pkg::SUM_BITS-1:0] w_sum;
    logic [tpms_pkg::SUM_BITS-1:0] w_new_max;
    logic [CMP_W-1:0]              w_rc_ext;
    logic [CNT_W-1:0]              w_count;
    tpms_pkg::t_chain_ctl          w_ctl;

    // position inside the triangle
    assign w_row_end   = (r_col >= r_row);
    assign w_last_row  = (r_row >= r_last_idx);   // also true if row_count shrank mid-triangle
    assign w_done      = w_row_end && w_last_row;
    assign w_has_above = (r_col < r_row);

    // only the final element can be held up, and only by an unread result
    assign s_axis_tready = !(w_done && r_out_valid && !m_axis_tready);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_value       = s_axis_tdata[VALUE_BITS-1:0];

    // best parent: left parent if any, above parent if it exists and is larger
    always_comb begin
        w_parent = (r_col != '0) ? r_left : '0;
        if (w_has_above && (w_above > w_parent)) begin
            w_parent = w_above;
        end
    end

    // saturating add
    assign w_wide    = ADD_W'(w_parent) + ADD_W'(w_value);
    assign w_sum     = (w_wide > ADD_W'(tpms_pkg::SUM_MAX)) ? tpms_pkg::SUM_MAX
                                                            : w_wide[tpms_pkg::SUM_BITS-1:0];
    assign w_new_max = (w_last_row && (w_sum > r_max)) ? w_sum : r_max;

    // row buffer: every element stores its sum, the head is consumed when it had a parent above
    assign w_ctl.clear = w_accept && w_done;
    assign w_ctl.push  = w_accept;
    assign w_ctl.pop   = w_accept && w_has_above;

    tpms_chain #(
        .MAX_ROWS (MAX_ROWS)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_sum   (w_sum),
        .o_head  (w_above),
        .o_count (w_count)
    );

    // row count write: zero means one row, large values clamp to the buffer depth
    assign w_rc_ext = CMP_W'(i_cfg_wdata);

    always_comb begin
        n_last_idx = r_last_idx;
        if (i_cfg_we) begin
            if (w_rc_ext == '0) begin
                n_last_idx = '0;
            end else if (w_rc_ext > CMP_W'(MAX_ROWS)) begin
                n_last_idx = IDX_W'(MAX_ROWS - 1);
            end else begin
                n_last_idx = IDX_W'(w_rc_ext - CMP_W'(1));
            end
        end
    end

    // walk through rows and columns
    always_comb begin
        n_row  = r_row;
        n_col  = r_col;
        n_left = r_left;
        n_max  = r_max;
        if (w_accept) begin
            n_left = w_above;
            n_max  = w_new_max;
            if (w_done) begin
                n_row  = '0;
                n_col  = '0;
                n_left = '0;
                n_max  = '0;
            end else if (w_row_end) begin
                n_row  = r_row + IDX_W'(1);
                n_col  = '0;
                n_left = '0;
            end else begin
                n_col  = r_col + IDX_W'(1);
            end
        end
    end

    // result register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_sum   = r_out_sum;
        if (w_accept && w_done) begin
            n_out_valid = 1'b1;
            n_out_sum   = w_new_max;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_idx  <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_left      <= '0;
            r_max       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_last_idx  <= n_last_idx;
            r_row       <= n_row;
            r_col       <= n_col;
            r_left      <= n_left;
            r_max       <= n_max;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_sum <= n_out_sum;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = tpms_pkg::OUT_TDATA_BITS'(r_out_sum);

    // the chain holds exactly the previous row while a row is in progress
    `TPMS_ASSERT_NOW(a_count_tracks_row, 1'b1, w_count == CNT_W'(r_row), "chain fill count off")
    `TPMS_ASSERT_NOW(a_col_in_row, 1'b1, r_col <= r_row, "column ran past row end")
    `TPMS_ASSERT_NEXT(a_done_gives_result, w_accept && w_done, r_out_valid, "result not loaded")
    `TPMS_ASSERT_NOW(a_stall_needs_result, !s_axis_tready, r_out_valid, "stall without result")

endmodule

FILE: rtl/tpms_cell.sv
// one cell of the row buffer chain: holds one path sum
// depends on tpms_pkg
module tpms_cell (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic                          i_shift,
    input  logic [tpms_pkg::SUM_BITS-1:0] i_new,
    input  logic [tpms_pkg::SUM_BITS-1:0] i_next,
    output logic [tpms_pkg::SUM_BITS-1:0] o_sum
);

    logic [tpms_pkg::SUM_BITS-1:0] r_sum;
    logic [tpms_pkg::SUM_BITS-1:0] n_sum;

    always_comb begin
        if (i_load) begin
            n_sum = i_new;
        end else if (i_shift) begin
            n_sum = i_next;
        end else begin
            n_sum = r_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
    end

    assign o_sum = r_sum;

endmodule

FILE: rtl/tpms_chain.sv
// row buffer built as a chain of cells, head at cell 0, fill count at the tail
// depends on tpms_pkg and tpms_cell
module tpms_chain #(
    parameter int MAX_ROWS = tpms_pkg::DEF_MAX_ROWS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tpms_pkg::t_chain_ctl                i_ctl,
    input  logic [tpms_pkg::SUM_BITS-1:0]       i_sum,
    output logic [tpms_pkg::SUM_BITS-1:0]       o_head,
    output logic [$clog2(MAX_ROWS + 1)-1:0]     o_count
);

    localparam int CNT_W = $clog2(MAX_ROWS + 1);

    logic [CNT_W-1:0]              r_count;
    logic [CNT_W-1:0]              n_count;
    logic [CNT_W-1:0]              w_ins;
    logic [tpms_pkg::SUM_BITS-1:0] w_tap [0:MAX_ROWS];

    // tail slot after this cycle's shift
    assign w_ins = i_ctl.pop ? (r_count - CNT_W'(1)) : r_count;

    always_comb begin
        if (i_ctl.clear) begin
            n_count = '0;
        end else if (i_ctl.push && !i_ctl.pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_ctl.push && i_ctl.pop) begin
            n_count = r_count - CNT_W'(1);
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign w_tap[MAX_ROWS] = '0;

    for (genvar k = 0; k < MAX_ROWS; k++) begin : g_cell
        tpms_cell u_cell (
            .i_clk   (i_clk),
            .i_load  (i_ctl.push && (w_ins == CNT_W'(k))),
            .i_shift (i_ctl.pop),
            .i_new   (i_sum),
            .i_next  (w_tap[k + 1]),
            .o_sum   (w_tap[k])
        );
    end

    assign o_head  = w_tap[0];
    assign o_count = r_count;

endmodule
